/* rtl/vss_pkg.sv */
// shared types and constants of the video scanner and soft-switch block
package vss_pkg;

  typedef enum logic [1:0] {
    ACT_SWITCH    = 2'd0,
    ACT_MODE_READ = 2'd1,
    ACT_VBL_READ  = 2'd2,
    ACT_SCAN      = 2'd3
  } action_t;

  // one bit per video mode, text in the lowest position
  typedef struct packed {
    logic altchar;
    logic dhires;
    logic col80;
    logic store80;
    logic hires;
    logic page2;
    logic mixed;
    logic text;
  } mode_flags_t;

  // configuration register indexes
  localparam logic CFG_PAL_TIMING     = 1'b0;
  localparam logic CFG_ORIGINAL_MODEL = 1'b1;

  // soft-switch addresses
  localparam logic [7:0] SW_80STORE_OFF = 8'h00;
  localparam logic [7:0] SW_80STORE_ON  = 8'h01;
  localparam logic [7:0] SW_80COL_OFF   = 8'h0C;
  localparam logic [7:0] SW_80COL_ON    = 8'h0D;
  localparam logic [7:0] SW_ALTCHAR_OFF = 8'h0E;
  localparam logic [7:0] SW_ALTCHAR_ON  = 8'h0F;
  localparam logic [7:0] SW_TEXT_OFF    = 8'h50;
  localparam logic [7:0] SW_TEXT_ON     = 8'h51;
  localparam logic [7:0] SW_MIXED_OFF   = 8'h52;
  localparam logic [7:0] SW_MIXED_ON    = 8'h53;
  localparam logic [7:0] SW_PAGE2_OFF   = 8'h54;
  localparam logic [7:0] SW_PAGE2_ON    = 8'h55;
  localparam logic [7:0] SW_HIRES_OFF   = 8'h56;
  localparam logic [7:0] SW_HIRES_ON    = 8'h57;
  localparam logic [7:0] SW_DHIRES_ON   = 8'h5E;
  localparam logic [7:0] SW_DHIRES_OFF  = 8'h5F;

  // status read addresses
  localparam logic [7:0] RD_TEXT    = 8'h1A;
  localparam logic [7:0] RD_MIXED   = 8'h1B;
  localparam logic [7:0] RD_HIRES   = 8'h1D;
  localparam logic [7:0] RD_ALTCHAR = 8'h1E;
  localparam logic [7:0] RD_80COL   = 8'h1F;
  localparam logic [7:0] RD_FLOAT   = 8'h7F;

  // scanner timing
  localparam int H_CLOCKS    = 65;
  localparam int H_STATE0    = 'h18;
  localparam int H_PE_CLOCK  = 40;
  localparam int H_PRESET    = 41;
  localparam int V_STATE0    = 'h100;
  localparam int V_PRESET    = 256;
  localparam int LINES_NTSC  = 262;
  localparam int LINES_PAL   = 312;
  localparam int LINES_SHOWN = 192;

  localparam int FRAME_NTSC = LINES_NTSC * H_CLOCKS;
  localparam int FRAME_PAL  = LINES_PAL * H_CLOCKS;
  localparam int VBL_START  = LINES_SHOWN * H_CLOCKS;

  // x / 65 == (x * 16132) >> 20, exact for x below 2^18
  localparam int DIV65_MULT  = 16132;
  localparam int DIV65_SHIFT = 20;

endpackage

/* rtl/vss_frame_reduce.sv */
// reduces the frame cycle count modulo the frame length
module vss_frame_reduce import vss_pkg::*; (
  input  logic [15:0] frame_cycles,
  input  logic        pal_timing,
  output logic [14:0] cyc
);

  logic [16:0] len1, len2, len3;
  logic [16:0] d1, d2, d3;

  always_comb begin
    if (pal_timing) begin
      len1 = 17'(FRAME_PAL);
      len2 = 17'(2 * FRAME_PAL);
      len3 = 17'(3 * FRAME_PAL);
    end else begin
      len1 = 17'(FRAME_NTSC);
      len2 = 17'(2 * FRAME_NTSC);
      len3 = 17'(3 * FRAME_NTSC);
    end
    d1 = {1'b0, frame_cycles} - len1;
    d2 = {1'b0, frame_cycles} - len2;
    d3 = {1'b0, frame_cycles} - len3;
    // a clear borrow bit means the count reaches that multiple
    if (!d3[16]) begin
      cyc = d3[14:0];
    end else if (!d2[16]) begin
      cyc = d2[14:0];
    end else if (!d1[16]) begin
      cyc = d1[14:0];
    end else begin
      cyc = frame_cycles[14:0];
    end
  end

endmodule

/* rtl/vss_scanner.sv */
// horizontal and vertical scanner states and the scanned memory address
module vss_scanner import vss_pkg::*; (
  input  logic [14:0]  cyc,
  input  mode_flags_t  flags,
  input  logic         pal_timing,
  input  logic         original_model,
  output logic [14:0]  scanner_address,
  output logic         vbl_bar
);

  logic [28:0] prod;
  logic [8:0]  line;
  logic [14:0] line_x65;
  logic [6:0]  rem;
  logic [7:0]  hsum;
  logic [6:0]  hclk;
  logic [6:0]  hs;
  logic [9:0]  vs;
  logic [9:0]  lines;
  logic        h3, h4, h5, v0, v1, v2, v3, v4;
  logic [3:0]  sum;
  logic        hires;
  logic        p2;

  always_comb begin
    prod     = 29'(cyc) * 29'(DIV65_MULT);
    line     = prod[28:DIV65_SHIFT];
    line_x65 = 15'({line, 6'b0}) + 15'(line);
    rem      = 7'(cyc - line_x65);

    hsum = 8'(rem) + 8'(H_PE_CLOCK);
    hclk = (hsum >= 8'(H_CLOCKS)) ? 7'(hsum - 8'(H_CLOCKS)) : hsum[6:0];
    hs   = 7'(H_STATE0) + hclk;
    if (hclk >= 7'(H_PRESET)) begin
      hs = hs - 7'd1;
    end

    lines = pal_timing ? 10'(LINES_PAL) : 10'(LINES_NTSC);
    vs    = 10'(V_STATE0) + 10'(line);
    if (line >= 9'(V_PRESET)) begin
      vs = vs - lines;
    end

    h3 = hs[3];
    h4 = hs[4];
    h5 = hs[5];
    v0 = vs[3];
    v1 = vs[4];
    v2 = vs[5];
    v3 = vs[6];
    v4 = vs[7];

    // mixed mode shows text in the bottom four rows
    hires = flags.hires && !flags.text && !(flags.mixed && v4 && v2);
    p2    = flags.page2 && !flags.store80;

    sum = 4'hD + {1'b0, h5, h4, h3} + {v4, v3, v4, v3};

    scanner_address = {5'b0, v2, v1, v0, sum, hs[2:0]};
    if (hires) begin
      scanner_address[12:10] = vs[2:0];
      scanner_address[13]    = !p2;
      scanner_address[14]    = p2;
    end else begin
      scanner_address[10] = !p2;
      scanner_address[11] = p2;
      // text HBL address bit of the original machine
      scanner_address[12] = original_model && !h5 && (!h4 || !h3);
    end

    vbl_bar = !(v4 && v3);
  end

endmodule

/* rtl/vss_switches.sv */
// video mode flag register, soft-switch decode and mode status read
module vss_switches import vss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        upd_en,
  input  logic [7:0]  switch_addr,
  input  logic [7:0]  key_code,
  input  logic        original_model,
  output mode_flags_t flags,
  output logic [7:0]  status_byte
);

  mode_flags_t flags_r, flags_nxt;
  logic        later;
  logic        sel;

  assign later = !original_model;
  assign flags = flags_r;

  always_comb begin
    flags_nxt = flags_r;
    case (switch_addr)
      SW_80STORE_OFF: flags_nxt.store80 = 1'b0;
      SW_80STORE_ON:  flags_nxt.store80 = 1'b1;
      SW_80COL_OFF:   if (later) flags_nxt.col80 = 1'b0;
      SW_80COL_ON:    if (later) flags_nxt.col80 = 1'b1;
      SW_ALTCHAR_OFF: if (later) flags_nxt.altchar = 1'b0;
      SW_ALTCHAR_ON:  if (later) flags_nxt.altchar = 1'b1;
      SW_TEXT_OFF:    flags_nxt.text = 1'b0;
      SW_TEXT_ON:     flags_nxt.text = 1'b1;
      SW_MIXED_OFF:   flags_nxt.mixed = 1'b0;
      SW_MIXED_ON:    flags_nxt.mixed = 1'b1;
      SW_PAGE2_OFF:   flags_nxt.page2 = 1'b0;
      SW_PAGE2_ON:    flags_nxt.page2 = 1'b1;
      SW_HIRES_OFF:   flags_nxt.hires = 1'b0;
      SW_HIRES_ON:    flags_nxt.hires = 1'b1;
      SW_DHIRES_ON:   if (later) flags_nxt.dhires = 1'b1;
      SW_DHIRES_OFF:  if (later) flags_nxt.dhires = 1'b0;
      default: ;
    endcase
    // 80store always forces page2 off
    if (flags_nxt.store80) begin
      flags_nxt.page2 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (upd_en) begin
      flags_r <= flags_nxt;
    end
  end

  always_comb begin
    case (switch_addr)
      RD_TEXT:    sel = flags_r.text;
      RD_MIXED:   sel = flags_r.mixed;
      RD_HIRES:   sel = flags_r.hires;
      RD_ALTCHAR: sel = flags_r.altchar;
      RD_80COL:   sel = flags_r.col80;
      default:    sel = 1'b0;
    endcase
    if (switch_addr == RD_FLOAT) begin
      status_byte = 8'h00;
    end else begin
      status_byte = key_code | {sel, 7'b0};
    end
  end

endmodule

/* rtl/video_scanner_soft_switches_core.sv */
// top level: soft-switch flags, status reads and video scanner address queries
// One beat is taken per clock until a stalled output fills the pipeline, and
// one result beat is given for each; it passes the input, frame reduction and
// result registers in turn, the frame reduction and the divide-by-65 of the
// scanner each filling one of these register-to-register paths. Each stage
// holds its beat while the next one is stalled, so a stalled output fills the
// pipeline before in_tready drops. Soft-switch beats update the mode flags in
// the last stage, so later beats always see the new flags.
module video_scanner_soft_switches_core import vss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic        cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // switch_addr[7:0], frame_cycles[23:8], key_code[31:24]
  input  logic [1:0]  in_tuser,   // action[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // data_byte[7:0], scanner_address[22:8], vbl_bar[23]
);

  logic        pal_r, orig_r;

  logic        valid1_r, valid2_r, out_valid_r;
  logic        ready1, ready2;
  action_t     act1_r, act2_r;
  logic [7:0]  sa1_r, sa2_r;
  logic [15:0] fc1_r;
  logic [7:0]  key1_r, key2_r;
  logic [14:0] cyc2_r;
  logic [14:0] cyc_red;

  mode_flags_t flags;
  logic [7:0]  status_byte;
  logic [14:0] scan_addr;
  logic        scan_vbl;
  logic        flag_upd;

  logic [7:0]  data_r, data_nxt;
  logic [14:0] addr_r, addr_nxt;
  logic        vbl_r, vbl_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_r  <= 1'b0;
      orig_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PAL_TIMING:     pal_r  <= cfg_wdata;
        CFG_ORIGINAL_MODEL: orig_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign ready2    = !out_valid_r || out_tready;
  assign ready1    = !valid2_r || ready2;
  assign in_tready = !valid1_r || ready1;

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
    end else if (in_tready) begin
      valid1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      act1_r <= action_t'(in_tuser);
      sa1_r  <= in_tdata[7:0];
      fc1_r  <= in_tdata[23:8];
      key1_r <= in_tdata[31:24];
    end
  end

  vss_frame_reduce u_reduce (
    .frame_cycles (fc1_r),
    .pal_timing   (pal_r),
    .cyc          (cyc_red)
  );

  // stage 2: reduced frame position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid2_r <= 1'b0;
    end else if (ready1) begin
      valid2_r <= valid1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && valid1_r) begin
      act2_r <= act1_r;
      sa2_r  <= sa1_r;
      key2_r <= key1_r;
      cyc2_r <= cyc_red;
    end
  end

  assign flag_upd = valid2_r && ready2 && (act2_r == ACT_SWITCH);

  vss_switches u_switches (
    .clk            (clk),
    .rst_n          (rst_n),
    .upd_en         (flag_upd),
    .switch_addr    (sa2_r),
    .key_code       (key2_r),
    .original_model (orig_r),
    .flags          (flags),
    .status_byte    (status_byte)
  );

  vss_scanner u_scanner (
    .cyc             (cyc2_r),
    .flags           (flags),
    .pal_timing      (pal_r),
    .original_model  (orig_r),
    .scanner_address (scan_addr),
    .vbl_bar         (scan_vbl)
  );

  always_comb begin
    data_nxt = 8'h00;
    addr_nxt = 15'h0000;
    vbl_nxt  = 1'b0;
    case (act2_r)
      ACT_SWITCH: ;
      ACT_MODE_READ: data_nxt = status_byte;
      ACT_VBL_READ: begin
        vbl_nxt  = (cyc2_r < 15'(VBL_START));
        data_nxt = {vbl_nxt, key2_r[6:0]};
      end
      ACT_SCAN: begin
        addr_nxt = scan_addr;
        vbl_nxt  = scan_vbl;
      end
      default: ;
    endcase
  end

  // stage 3: result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ready2) begin
      out_valid_r <= valid2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && valid2_r) begin
      data_r <= data_nxt;
      addr_r <= addr_nxt;
      vbl_r  <= vbl_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {vbl_r, addr_r, data_r};

endmodule

/* verif/vss_result_checker.sv */
// result checker for the soft-switch and video scanner block: predicts every result beat
`timescale 1ns / 100ps

module vss_result_checker import vss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // switch_addr[7:0], frame_cycles[23:8], key_code[31:24]
  input  logic [1:0]  in_tuser,   // action[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // data_byte[7:0], scanner_address[22:8], vbl_bar[23]
  output int          mismatch_count,
  output int          outstanding,
  output int          results_checked
);

  localparam logic [3:0] ROW_SUM_BIAS = 4'hD;
  localparam int         MAX_REPORTS  = 10;

  typedef struct packed {
    logic        vbl_bar;
    logic [14:0] scanner_address;
    logic [7:0]  data_byte;
  } result_t;

  typedef struct {
    result_t res;
    action_t act;
    int      seq;
  } expected_beat_t;

  expected_beat_t pending_results[$];
  mode_flags_t    modes;
  logic           pal_frame;
  logic           original_hw;
  int             beat_seq;
  int             errors;
  int             checked;
  expected_beat_t head;
  result_t        got;

  function automatic void apply_switch(logic [7:0] sa);
    logic later;
    later = !original_hw;
    case (sa)
      SW_80STORE_OFF: modes.store80 = 1'b0;
      SW_80STORE_ON:  modes.store80 = 1'b1;
      SW_80COL_OFF:   if (later) modes.col80 = 1'b0;
      SW_80COL_ON:    if (later) modes.col80 = 1'b1;
      SW_ALTCHAR_OFF: if (later) modes.altchar = 1'b0;
      SW_ALTCHAR_ON:  if (later) modes.altchar = 1'b1;
      SW_TEXT_OFF:    modes.text = 1'b0;
      SW_TEXT_ON:     modes.text = 1'b1;
      SW_MIXED_OFF:   modes.mixed = 1'b0;
      SW_MIXED_ON:    modes.mixed = 1'b1;
      SW_PAGE2_OFF:   modes.page2 = 1'b0;
      SW_PAGE2_ON:    modes.page2 = 1'b1;
      SW_HIRES_OFF:   modes.hires = 1'b0;
      SW_HIRES_ON:    modes.hires = 1'b1;
      SW_DHIRES_ON:   if (later) modes.dhires = 1'b1;
      SW_DHIRES_OFF:  if (later) modes.dhires = 1'b0;
      default: ;
    endcase
    // 80store wins over page2 after any access
    if (modes.store80) modes.page2 = 1'b0;
  endfunction

  function automatic logic [7:0] status_byte(logic [7:0] sa, logic [7:0] key);
    logic flag;
    flag = 1'b0;
    if (sa == RD_FLOAT) return 8'h00;
    case (sa)
      RD_TEXT:    flag = modes.text;
      RD_MIXED:   flag = modes.mixed;
      RD_HIRES:   flag = modes.hires;
      RD_ALTCHAR: flag = modes.altchar;
      RD_80COL:   flag = modes.col80;
      default: ;
    endcase
    return key | {flag, 7'b0};
  endfunction

  function automatic logic [14:0] scanned_address(int cyc, output logic vbl_bar);
    int          hclk;
    int          hs;
    int          line;
    int          vs;
    logic [3:0]  row_sum;
    logic        h3, h4, h5, v0, v1, v2, v3, v4;
    logic        hires_on;
    logic        p2;
    logic [14:0] a;
    hclk = (cyc + H_PE_CLOCK) % H_CLOCKS;
    hs   = H_STATE0 + hclk;
    if (hclk >= H_PRESET) hs = hs - 1;
    line = cyc / H_CLOCKS;
    vs   = V_STATE0 + line;
    if (line >= V_PRESET) vs = vs - (pal_frame ? LINES_PAL : LINES_NTSC);
    h3 = hs[3]; h4 = hs[4]; h5 = hs[5];
    v0 = vs[3]; v1 = vs[4]; v2 = vs[5]; v3 = vs[6]; v4 = vs[7];
    hires_on = modes.hires && !modes.text;
    // mixed mode drops to text for the bottom rows
    if (hires_on && modes.mixed && v4 && v2) hires_on = 1'b0;
    row_sum = ROW_SUM_BIAS + {1'b0, h5, h4, h3} + {v4, v3, v4, v3};
    a = '0;
    a[2:0] = hs[2:0];
    a[6:3] = row_sum;
    a[7]   = v0;
    a[8]   = v1;
    a[9]   = v2;
    p2 = modes.page2 && !modes.store80;
    if (hires_on) begin
      a[12:10] = vs[2:0];
      a[13]    = !p2;
      a[14]    = p2;
    end else begin
      a[10] = !p2;
      a[11] = p2;
      if (original_hw && !h5 && (!h4 || !h3)) a[12] = 1'b1;
    end
    vbl_bar = !(v4 && v3);
    return a;
  endfunction

  function automatic result_t predict_result(action_t act, logic [7:0] sa, logic [15:0] fc,
                                             logic [7:0] key);
    result_t r;
    int      cyc;
    logic    vb;
    r   = '0;
    cyc = int'(fc) % (pal_frame ? FRAME_PAL : FRAME_NTSC);
    case (act)
      ACT_SWITCH:    apply_switch(sa);
      ACT_MODE_READ: r.data_byte = status_byte(sa, key);
      ACT_VBL_READ: begin
        r.vbl_bar   = cyc < VBL_START;
        r.data_byte = {r.vbl_bar, key[6:0]};
      end
      default: begin
        r.scanner_address = scanned_address(cyc, vb);
        r.vbl_bar         = vb;
      end
    endcase
    return r;
  endfunction

  initial begin
    mismatch_count  = 0;
    outstanding     = 0;
    results_checked = 0;
    modes           = '0;
    pal_frame       = 1'b0;
    original_hw     = 1'b0;
    beat_seq        = 0;
    errors          = 0;
    checked         = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      modes       = '0;
      pal_frame   = 1'b0;
      original_hw = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_PAL_TIMING) pal_frame = cfg_wdata;
        else if (cfg_addr == CFG_ORIGINAL_MODEL) original_hw = cfg_wdata;
      end
      // compare before predicting so a same-edge beat cannot hide an extra result
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        checked++;
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result beat %06h arrived with nothing outstanding", $time, out_tdata);
        end else begin
          head = pending_results.pop_front();
          if (got.data_byte !== head.res.data_byte ||
              got.scanner_address !== head.res.scanner_address ||
              got.vbl_bar !== head.res.vbl_bar) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: beat %0d (%s) data_byte %02h/%02h addr %04h/%04h vbl %b/%b (exp/got)",
                       $time, head.seq, head.act.name(), head.res.data_byte, got.data_byte,
                       head.res.scanner_address, got.scanner_address,
                       head.res.vbl_bar, got.vbl_bar);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        head.act = action_t'(in_tuser);
        head.seq = beat_seq++;
        head.res = predict_result(head.act, in_tdata[7:0], in_tdata[23:8], in_tdata[31:24]);
        pending_results.push_back(head);
      end
    end
    mismatch_count  <= errors;
    outstanding     <= pending_results.size();
    results_checked <= checked;
  end

endmodule

/* verif/video_scanner_soft_switches_core_test.sv */
// testbench top: clock, reset, configuration phases, stimulus and final verdict
`timescale 1ns / 100ps

module video_scanner_soft_switches_core_test import vss_pkg::*;;

  localparam int RANDOM_PER_PHASE = 190;
  localparam int PHASES           = 6;
  localparam int PIPE_SLACK       = 6;
  localparam int WATCHDOG_LIMIT   = 5000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_addr   = 1'b0;
  logic        cfg_wdata  = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  int mismatch_count;
  int outstanding;
  int results_checked;

  bit cur_pal;
  bit cur_orig;
  int beats_by_action[4];
  int gapless_left;
  int stall_left;
  int ready_run;
  int quiet_cycles;

  logic [7:0] switch_addrs[16] = '{
    SW_80STORE_OFF, SW_80STORE_ON, SW_80COL_OFF, SW_80COL_ON,
    SW_ALTCHAR_OFF, SW_ALTCHAR_ON, SW_TEXT_OFF, SW_TEXT_ON,
    SW_MIXED_OFF, SW_MIXED_ON, SW_PAGE2_OFF, SW_PAGE2_ON,
    SW_HIRES_OFF, SW_HIRES_ON, SW_DHIRES_ON, SW_DHIRES_OFF
  };
  logic [7:0] status_addrs[6] = '{
    RD_TEXT, RD_MIXED, RD_HIRES, RD_ALTCHAR, RD_80COL, RD_FLOAT
  };

  always #5 clk = ~clk;

  video_scanner_soft_switches_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  vss_result_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .mismatch_count  (mismatch_count),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  // result side back-pressure: mostly short stalls, some long ones, some free runs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
      ready_run  = 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (ready_run > 0) begin
        ready_run--;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9: ;
          10, 11, 12, 13, 14, 15: stall_left = $urandom_range(1, 3);
          16, 17: ready_run = $urandom_range(20, 80);
          default: stall_left = $urandom_range(8, 40);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
               quiet_cycles, outstanding);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_beat(action_t act, logic [7:0] sa, logic [15:0] fc, logic [7:0] key);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {key, fc, sa};
    do @(posedge clk); while (!in_tready);
    beats_by_action[act]++;
  endtask

  task automatic sender_gap();
    int n;
    n = 0;
    if (gapless_left > 0) begin
      gapless_left--;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: n = $urandom_range(1, 3);
        6, 7: n = $urandom_range(8, 30);
        8: gapless_left = $urandom_range(30, 80);
        default: n = 0;
      endcase
    end
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold the sender until every outstanding result is back, then let the pipe settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  task automatic set_config(bit pal, bit orig);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_PAL_TIMING;
    cfg_wdata <= pal;
    @(posedge clk);
    cfg_addr  <= CFG_ORIGINAL_MODEL;
    cfg_wdata <= orig;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_pal  = pal;
    cur_orig = orig;
  endtask

  function automatic logic [15:0] pick_cycles();
    int frame;
    frame = cur_pal ? FRAME_PAL : FRAME_NTSC;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($urandom);
      4, 5: return 16'($urandom_range(0, frame - 1));
      // around the horizontal preset and the start of a line
      6: return 16'($urandom_range(0, frame / H_CLOCKS - 1) * H_CLOCKS + $urandom_range(0, 3)
                    + ($urandom_range(0, 1) ? H_CLOCKS - 2 : 0));
      7: return 16'(frame - 2 + $urandom_range(0, 3));
      8: return 16'(($urandom_range(0, 1) ? VBL_START : V_PRESET * H_CLOCKS)
                    - 2 + $urandom_range(0, 3));
      default: return 16'(frame * $urandom_range(1, 3) + $urandom_range(0, H_CLOCKS));
    endcase
  endfunction

  task automatic send_random();
    action_t    act;
    logic [7:0] sa;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 30) act = ACT_SWITCH;
    else if (r < 50) act = ACT_MODE_READ;
    else if (r < 65) act = ACT_VBL_READ;
    else act = ACT_SCAN;
    sa = 8'($urandom);
    if (act == ACT_SWITCH && $urandom_range(0, 4) != 0)
      sa = switch_addrs[$urandom_range(0, 15)];
    else if (act == ACT_MODE_READ && $urandom_range(0, 3) != 0)
      sa = status_addrs[$urandom_range(0, 5)];
    send_beat(act, sa, pick_cycles(), 8'($urandom));
    sender_gap();
  endtask

  task automatic send_directed();
    send_beat(ACT_SWITCH, SW_TEXT_ON, 16'h0000, 8'h00);
    send_beat(ACT_SWITCH, SW_HIRES_ON, 16'hFFFF, 8'hFF);
    send_beat(ACT_SWITCH, SW_PAGE2_ON, 16'h0000, 8'h00);
    send_beat(ACT_SCAN, 8'h00, 16'h0000, 8'hFF);
    // 80store on must knock page2 off
    send_beat(ACT_SWITCH, SW_80STORE_ON, 16'h0000, 8'h00);
    send_beat(ACT_MODE_READ, RD_TEXT, 16'h0000, 8'h00);
    send_beat(ACT_MODE_READ, RD_FLOAT, 16'hFFFF, 8'hFF);
    send_beat(ACT_MODE_READ, RD_HIRES, 16'h0000, 8'h7F);
    send_beat(ACT_VBL_READ, 8'h00, 16'(VBL_START - 1), 8'hFF);
    send_beat(ACT_VBL_READ, 8'hFF, 16'(VBL_START), 8'h00);
    send_beat(ACT_VBL_READ, 8'h00, 16'hFFFF, 8'hAA);
    send_beat(ACT_SWITCH, SW_TEXT_OFF, 16'h0000, 8'h00);
    send_beat(ACT_SWITCH, SW_MIXED_ON, 16'h0000, 8'h00);
    send_beat(ACT_SCAN, 8'hFF, 16'hFFFF, 8'h00);
    send_beat(ACT_SCAN, 8'h00, 16'(160 * H_CLOCKS + 10), 8'h55);
    send_beat(ACT_SWITCH, SW_DHIRES_ON, 16'h0000, 8'h00);
    send_beat(ACT_SWITCH, SW_80COL_ON, 16'h0000, 8'h00);
    send_beat(ACT_SWITCH, SW_ALTCHAR_ON, 16'h0000, 8'h00);
    send_beat(ACT_MODE_READ, RD_80COL, 16'h0000, 8'h00);
    send_beat(ACT_MODE_READ, RD_ALTCHAR, 16'h0000, 8'h01);
    send_beat(ACT_MODE_READ, RD_MIXED, 16'h0000, 8'h80);
    // unlisted address changes nothing
    send_beat(ACT_SWITCH, 8'hFF, 16'h0000, 8'h00);
    send_beat(ACT_SWITCH, SW_80STORE_OFF, 16'h0000, 8'h00);
    send_beat(ACT_SCAN, 8'h00, 16'(FRAME_NTSC - 1), 8'h00);
    send_beat(ACT_SCAN, 8'h00, 16'(FRAME_NTSC), 8'h00);
  endtask

  initial begin
    gapless_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: set_config(1'b0, 1'b0);
        1: set_config(1'b1, 1'b0);
        2: set_config(1'b1, 1'b1);
        3: set_config(1'b0, 1'b1);
        default: set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
      if (p == 0) send_directed();
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (p == 2 && i == RANDOM_PER_PHASE / 2) drain_results();
        send_random();
      end
    end
    drain_results();
    $display("covered %0d switch, %0d mode read, %0d vbl read, %0d scanner beats",
             beats_by_action[ACT_SWITCH], beats_by_action[ACT_MODE_READ],
             beats_by_action[ACT_VBL_READ], beats_by_action[ACT_SCAN]);
    $display("over %0d timing/model settings; %0d results compared, %0d wrong",
             PHASES, results_checked, mismatch_count);
    if (mismatch_count == 0 && outstanding == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/vss_pkg.sv
rtl/vss_frame_reduce.sv
rtl/vss_scanner.sv
rtl/vss_switches.sv
rtl/video_scanner_soft_switches_core.sv
verif/vss_result_checker.sv
verif/video_scanner_soft_switches_core_test.sv
